// ===== design/mttsf_pkg.sv =====
package mttsf_pkg;

    localparam int NUM_CHANNELS = 5;
    localparam int RING_DEPTH   = 8;
    localparam int SAMPLE_BITS  = 10;

    localparam int CH_BITS      = 3;
    localparam int SUM_BITS     = 13;
    localparam int AVG_BITS     = 10;
    localparam int TRUST_BITS   = 8;
    localparam int MODE_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam int RING_ENTRIES = NUM_CHANNELS * RING_DEPTH;
    localparam int ADDR_BITS    = $clog2(RING_ENTRIES);
    localparam int SLOT_BITS    = $clog2(RING_DEPTH);
    localparam int RING_SHIFT   = $clog2(RING_DEPTH);
    localparam int CH_IDX_BITS  = $clog2(NUM_CHANNELS);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PLAIN = 2'd0,
        MODE_HALVE = 2'd1,
        MODE_TREND = 2'd2
    } t_mode;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRUST_MAX   = 2'd1;

    localparam logic [MODE_BITS-1:0]  MODE_RESET      = MODE_TREND;
    localparam logic [TRUST_BITS-1:0] TRUST_MAX_RESET = 8'd128;

    typedef struct packed {
        logic [CH_BITS-1:0]     ch;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   missing;
        logic                   in_range;
        logic [ADDR_BITS-1:0]   addr;
    } t_item;

endpackage

// ===== design/multichannel_trend_trust_sensor_filter_core.sv =====
// Channel  Direction  Handshake              Word
// in       input      i_in_valid/o_in_stall  channel, sample, missing flag, frame end
// out      output     o_out_valid/i_out_stall channel, window sum, window average
// cfg      input      i_cfg_valid/o_cfg_ready register index, write data
//
// One word per cycle sustained while i_out_stall is low. The edge that accepts a
// word reads the ring into the stage-2 register; the output register is loaded
// when stage 2 advances.
// The ring is one memory read on accept and written back when stage 2 advances; a
// one-deep bypass covers a read that meets the write to the same entry.
// Reset is synchronous; ring entries carry valid bits, so no clearing pass.
// o_in_stall rises only when the stage holding the read data and the output
// register are both full and i_out_stall is high.
module multichannel_trend_trust_sensor_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mttsf_pkg::CH_BITS-1:0]     i_channel,
    input  logic [mttsf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                              i_sample_missing,
    input  logic                              i_end_of_frame,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mttsf_pkg::CH_BITS-1:0]     o_out_channel,
    output logic [mttsf_pkg::SUM_BITS-1:0]    o_window_sum,
    output logic [mttsf_pkg::AVG_BITS-1:0]    o_window_average,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mttsf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [mttsf_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import mttsf_pkg::*;

    // configuration
    logic [MODE_BITS-1:0]  r_filter_mode;
    logic [TRUST_BITS-1:0] r_trust_max;

    // ring memory and its valid bits
    logic [SAMPLE_BITS-1:0] r_ring [RING_ENTRIES];
    logic [RING_ENTRIES-1:0] r_ring_vld;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic                   r_fwd_hit;
    logic [SAMPLE_BITS-1:0] r_fwd_data;

    // per-channel state, read and written in the same stage
    logic [SUM_BITS-1:0]   r_chan_sum [NUM_CHANNELS];
    logic [TRUST_BITS-1:0] r_trust    [NUM_CHANNELS];
    logic                  r_last_dir [NUM_CHANNELS];
    logic [SLOT_BITS-1:0]  r_write_slot;

    // pipeline
    t_item r_s2;
    logic  r_s2_valid;
    logic  r_o_valid;
    logic [CH_BITS-1:0]  r_o_channel;
    logic [SUM_BITS-1:0] r_o_sum;
    logic [AVG_BITS-1:0] r_o_avg;

    logic accept;
    logic adv2;
    logic in_range;
    logic [ADDR_BITS-1:0] rd_addr;

    logic [CH_IDX_BITS-1:0]  ci;
    logic [SAMPLE_BITS-1:0]  old_val;
    logic [SAMPLE_BITS-1:0]  s_eff;
    logic [SUM_BITS-1:0]     sum_cur;
    logic [TRUST_BITS-1:0]   trust_cur;
    logic                    dir_cur;
    logic [SAMPLE_BITS-1:0]  avg_cur;
    logic [SAMPLE_BITS-1:0]  entry;
    logic [TRUST_BITS-1:0]   trust_new;
    logic                    dir_new;
    logic [SUM_BITS-1:0]     new_sum;
    logic                    ring_we;
    logic                    trend_we;

    assign adv2       = r_s2_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_s2_valid && !adv2;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign in_range = (int'(i_channel) < NUM_CHANNELS);
    assign rd_addr  = in_range
                    ? ADDR_BITS'(int'(i_channel) * RING_DEPTH + int'(r_write_slot))
                    : '0;

    assign ci = r_s2.ch[CH_IDX_BITS-1:0];

    always_comb begin
        logic [TRUST_BITS-1:0]  t0;
        logic                   dir;
        logic [TRUST_BITS:0]    td;
        logic [TRUST_BITS-1:0]  tc;
        logic [SAMPLE_BITS:0]   hi;
        logic [SAMPLE_BITS:0]   lo_chk;
        logic [SAMPLE_BITS:0]   half_sum;

        old_val = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);
        s_eff   = r_s2.missing ? old_val : r_s2.sample;

        sum_cur   = r_s2.in_range ? r_chan_sum[ci] : '0;
        trust_cur = r_s2.in_range ? r_trust[ci]    : '0;
        dir_cur   = r_s2.in_range ? r_last_dir[ci] : 1'b0;
        avg_cur   = SAMPLE_BITS'(sum_cur >> RING_SHIFT);

        // trend-trust step
        t0  = (trust_cur == '0) ? TRUST_BITS'(1) : trust_cur;
        dir = (s_eff > avg_cur);
        td  = (dir != dir_cur) ? (TRUST_BITS+1)'(1) : {t0, 1'b0};
        tc  = (td > {1'b0, r_trust_max}) ? r_trust_max : td[TRUST_BITS-1:0];
        hi     = {1'b0, avg_cur} + (SAMPLE_BITS+1)'(tc);
        lo_chk = {1'b0, s_eff} + (SAMPLE_BITS+1)'(tc);
        half_sum = {1'b0, old_val} + {1'b0, s_eff};

        trust_new = trust_cur;
        dir_new   = dir_cur;
        case (r_filter_mode)
            MODE_HALVE: begin
                entry = half_sum[SAMPLE_BITS:1];
            end
            MODE_TREND: begin
                if (s_eff == avg_cur) begin
                    entry     = s_eff;
                    trust_new = TRUST_BITS'(1);
                end else if ({1'b0, s_eff} > hi) begin
                    entry     = hi[SAMPLE_BITS-1:0];
                    trust_new = tc;
                    dir_new   = dir;
                end else if (lo_chk < {1'b0, avg_cur}) begin
                    entry     = avg_cur - SAMPLE_BITS'(tc);
                    trust_new = tc;
                    dir_new   = dir;
                end else begin
                    entry     = s_eff;
                    trust_new = tc >> 2;
                    dir_new   = dir;
                end
            end
            default: begin
                // plain, and the unused code acts as plain
                entry = s_eff;
            end
        endcase

        new_sum = r_s2.in_range
                ? sum_cur - SUM_BITS'(old_val) + SUM_BITS'(entry)
                : '0;
    end

    assign ring_we  = adv2 && r_s2.in_range;
    assign trend_we = ring_we && (r_filter_mode == MODE_TREND);

    // ring memory: registered read on accept, write-back from stage 2
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_s2.addr] <= entry;
        end
        if (accept) begin
            r_rd_data  <= r_ring[rd_addr];
            r_fwd_data <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= MODE_RESET;
            r_trust_max   <= TRUST_MAX_RESET;
            r_ring_vld    <= '0;
            r_rd_vld      <= 1'b0;
            r_fwd_hit     <= 1'b0;
            r_write_slot  <= '0;
            r_s2_valid    <= 1'b0;
            r_o_valid     <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_chan_sum[i] <= '0;
                r_trust[i]    <= '0;
                r_last_dir[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FILTER_MODE: r_filter_mode <= i_cfg_data[MODE_BITS-1:0];
                    CFG_TRUST_MAX:   r_trust_max   <= i_cfg_data[TRUST_BITS-1:0];
                    default: ;
                endcase
            end

            if (ring_we) begin
                r_ring_vld[r_s2.addr] <= 1'b1;
                r_chan_sum[ci]        <= new_sum;
            end
            if (trend_we) begin
                r_trust[ci]    <= trust_new;
                r_last_dir[ci] <= dir_new;
            end

            if (accept) begin
                r_rd_vld  <= r_ring_vld[rd_addr];
                // write landing on the entry read at this same edge
                r_fwd_hit <= ring_we && (r_s2.addr == rd_addr);
                if (i_end_of_frame) begin
                    if (r_write_slot == SLOT_BITS'(RING_DEPTH - 1)) begin
                        r_write_slot <= '0;
                    end else begin
                        r_write_slot <= r_write_slot + SLOT_BITS'(1);
                    end
                end
            end

            if (accept) begin
                r_s2_valid <= 1'b1;
            end else if (adv2) begin
                r_s2_valid <= 1'b0;
            end

            if (adv2) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2.ch       <= i_channel;
            r_s2.sample   <= i_sample[SAMPLE_BITS-1:0];
            r_s2.missing  <= i_sample_missing;
            r_s2.in_range <= in_range;
            r_s2.addr     <= rd_addr;
        end
        if (adv2) begin
            r_o_channel <= r_s2.ch;
            r_o_sum     <= new_sum;
            r_o_avg     <= AVG_BITS'(new_sum >> RING_SHIFT);
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_out_channel    = r_o_channel;
    assign o_window_sum     = r_o_sum;
    assign o_window_average = r_o_avg;

`ifndef SYNTH
    a_fwd_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ring_we && (r_s2.addr == rd_addr) |=> r_fwd_hit)
        else $error("bypass missed a same-entry write");

    a_avg_matches_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_window_average == AVG_BITS'(o_window_sum >> RING_SHIFT)))
        else $error("average does not follow sum");

    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (int'(o_out_channel) >= NUM_CHANNELS) |-> (o_window_sum == '0))
        else $error("out-of-range channel reported nonzero sum");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_out_stall && r_s2_valid |-> !accept)
        else $error("accepted a word with the pipeline full");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mttsf_pkg::*;

    // Predicts the per-channel window sum and average for each accepted word
    // and checks the block's result words against them in order.
    class window_checker;
        typedef struct {
            logic [CH_BITS-1:0]  ch;
            logic [SUM_BITS-1:0] sum;
            logic [AVG_BITS-1:0] avg;
        } t_window;

        logic [MODE_BITS-1:0]   mode;
        logic [TRUST_BITS-1:0]  trust_cap;
        logic [SAMPLE_BITS-1:0] ring[RING_ENTRIES];
        logic [SUM_BITS-1:0]    sums[NUM_CHANNELS];
        logic [TRUST_BITS-1:0]  trust[NUM_CHANNELS];
        logic                   rising[NUM_CHANNELS];
        int                     slot;
        t_window                expected_windows[$];
        int                     errors;

        function new();
            mode      = MODE_RESET;
            trust_cap = TRUST_MAX_RESET;
            foreach (ring[i]) ring[i] = '0;
            foreach (sums[i]) begin
                sums[i]   = '0;
                trust[i]  = '0;
                rising[i] = 1'b0;
            end
            slot   = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_windows.size();
        endfunction

        function void note_config(logic [CFG_IDX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_FILTER_MODE) begin
                mode = data[MODE_BITS-1:0];
            end else if (idx == CFG_TRUST_MAX) begin
                trust_cap = data[TRUST_BITS-1:0];
            end
        endfunction

        // trend-trust: limit the change about the average by an adaptive step
        function int limit_change(int ch, int s, int avg);
            int t;
            int entry;
            bit dir;
            t = int'(trust[ch]);
            if (t < 1) t = 1;
            if (s == avg) begin
                trust[ch] = 8'd1;
                return s;
            end
            dir = (s > avg);
            if (dir != rising[ch]) t = 1;
            else t = t << 1;
            if (t > int'(trust_cap)) t = int'(trust_cap);
            if (s > avg + t) begin
                entry = avg + t;
            end else if (s + t < avg) begin
                entry = avg - t;
            end else begin
                entry = s;
                t = t >> 2;
            end
            trust[ch]  = 8'(t);
            rising[ch] = dir;
            return entry;
        endfunction

        function void note_input(logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS-1:0] sample,
                                 logic missing, logic eof);
            t_window w;
            int c;
            int idx;
            int old;
            int s;
            int entry;
            int sum;
            c     = int'(ch);
            w.ch  = ch;
            w.sum = '0;
            w.avg = '0;
            if (c < NUM_CHANNELS) begin
                idx = c * RING_DEPTH + slot;
                old = int'(ring[idx]);
                s   = missing ? old : int'(sample);
                if (mode == MODE_HALVE) entry = (old + s) >> 1;
                else if (mode == MODE_TREND)
                    entry = limit_change(c, s, int'(sums[c]) / RING_DEPTH);
                else entry = s;
                ring[idx] = SAMPLE_BITS'(entry);
                sum       = int'(sums[c]) - old + entry;
                sums[c]   = SUM_BITS'(sum);
                w.sum     = SUM_BITS'(sum);
                w.avg     = AVG_BITS'(sum / RING_DEPTH);
            end
            if (eof) slot = (slot + 1) % RING_DEPTH;
            expected_windows.push_back(w);
        endfunction

        function void check_result(logic [CH_BITS-1:0] ch, logic [SUM_BITS-1:0] sum,
                                   logic [AVG_BITS-1:0] avg);
            t_window w;
            if (expected_windows.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: ch %0d sum %0d avg %0d", ch, sum, avg);
                errors++;
                return;
            end
            w = expected_windows.pop_front();
            if (ch !== w.ch || sum !== w.sum || avg !== w.avg) begin
                if (errors < 10) begin
                    $display("mismatch: expected ch %0d sum %0d avg %0d, got %0d %0d %0d",
                             w.ch, w.sum, w.avg, ch, sum, avg);
                end
                errors++;
            end
        endfunction
    endclass

    localparam int GAP_MAX         = 6;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 165;

    // modes and register indexes that the package leaves unnamed
    localparam logic [MODE_BITS-1:0]    MODE_SPARE     = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX3 = 2'd3;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_in_valid       = 1'b0;
    logic                     o_in_stall;
    logic [CH_BITS-1:0]       i_channel        = '0;
    logic [SAMPLE_BITS-1:0]   i_sample         = '0;
    logic                     i_sample_missing = 1'b0;
    logic                     i_end_of_frame   = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall      = 1'b0;
    logic [CH_BITS-1:0]       o_out_channel;
    logic [SUM_BITS-1:0]      o_window_sum;
    logic [AVG_BITS-1:0]      o_window_average;
    logic                     i_cfg_valid      = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data       = '0;

    window_checker sb;
    int            cycles = 0;
    bit            quiet  = 1'b0;   // no idling on either side while set
    bit            push_up[8];      // per-channel drift direction for ramps

    multichannel_trend_trust_sensor_filter_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_channel        (i_channel),
        .i_sample         (i_sample),
        .i_sample_missing (i_sample_missing),
        .i_end_of_frame   (i_end_of_frame),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_channel    (o_out_channel),
        .o_window_sum     (o_window_sum),
        .o_window_average (o_window_average),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a word is lost or the handshake hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Observe all three channels at the edge. Values read here are the
    // pre-edge ones, since every driver uses nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.note_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                sb.note_input(i_channel, i_sample, i_sample_missing, i_end_of_frame);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_channel, o_window_sum, o_window_average);
            end
        end
    end

    function automatic int draw_wait();
        return quiet ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    // Result side: stall for a random count, then take one word.
    initial begin : result_side
        int w;
        forever begin
            w = draw_wait();
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Present one sample word after a random gap and hold it until taken.
    task automatic send_word(logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS-1:0] s,
                             logic missing, logic eof);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_channel        <= ch;
        i_sample         <= s;
        i_sample_missing <= missing;
        i_end_of_frame   <= eof;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop sending and wait until every predicted window has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly in-range channels; samples are a mix of noise, values near or
    // at the average, rail values and steady ramps that keep one direction
    // so the trust step grows up to its cap.
    task automatic send_random();
        logic [CH_BITS-1:0] ch;
        int avg;
        int s;
        int c;
        int pick;
        bit missing;
        bit eof;
        if ($urandom_range(0, 9) == 0) ch = CH_BITS'($urandom_range(NUM_CHANNELS, 7));
        else ch = CH_BITS'($urandom_range(0, NUM_CHANNELS - 1));
        c    = int'(ch);
        avg  = (c < NUM_CHANNELS) ? int'(sb.sums[c]) / RING_DEPTH : 0;
        pick = int'($urandom_range(0, 9));
        if (pick < 3) begin
            s = int'($urandom_range(0, 1023));
        end else if (pick < 6) begin
            s = avg + int'($urandom_range(0, 16)) - 8;
        end else if (pick == 6) begin
            s = avg;
        end else if (pick == 7) begin
            s = $urandom_range(0, 1) ? 1023 : 0;
        end else begin
            if ($urandom_range(0, 7) == 0) push_up[c] = ~push_up[c];
            s = push_up[c] ? avg + int'($urandom_range(20, 400))
                           : avg - int'($urandom_range(20, 400));
        end
        if (s < 0) s = 0;
        if (s > 1023) s = 1023;
        missing = ($urandom_range(0, 9) == 0);
        eof     = ($urandom_range(0, 3) == 0);
        send_word(ch, SAMPLE_BITS'(s), missing, eof);
    endtask

    initial begin : stimulus
        logic [CFG_DATA_BITS-1:0] data;
        logic [MODE_BITS-1:0]     mode;
        int pause_at;
        int pick;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config (trend-trust, cap 128): rail values, trust doubling,
        // direction flip, sample equal to average, missing sample,
        // out-of-range channels with frame end
        send_word(3'd0, 10'd1023, 1'b0, 1'b0);
        send_word(3'd0, 10'd1023, 1'b0, 1'b0);
        send_word(3'd0, 10'd1023, 1'b0, 1'b0);
        send_word(3'd0, 10'd0,    1'b0, 1'b0);
        send_word(3'd1, 10'd0,    1'b0, 1'b0);
        send_word(3'd4, 10'd1023, 1'b1, 1'b0);
        send_word(3'd7, 10'd1023, 1'b0, 1'b1);
        send_word(3'd5, 10'd512,  1'b1, 1'b1);

        drain();
        write_reg(CFG_FILTER_MODE, {6'd0, MODE_PLAIN});
        send_word(3'd2, 10'd1023, 1'b0, 1'b0);
        send_word(3'd3, 10'd0,    1'b0, 1'b1);

        drain();
        write_reg(CFG_FILTER_MODE, {6'd0, MODE_HALVE});
        send_word(3'd0, 10'd1023, 1'b0, 1'b0);
        send_word(3'd0, 10'd1023, 1'b1, 1'b0);
        send_word(3'd6, 10'd0,    1'b0, 1'b1);

        // unused mode code acts as plain; upper data bits are don't-care
        drain();
        write_reg(CFG_FILTER_MODE, {6'h3f, MODE_SPARE});
        send_word(3'd1, 10'd700, 1'b0, 1'b1);

        // zero cap holds a differing sample at the average
        drain();
        write_reg(CFG_FILTER_MODE, {6'd0, MODE_TREND});
        write_reg(CFG_TRUST_MAX, 8'd0);
        send_word(3'd2, 10'd1023, 1'b0, 1'b0);
        send_word(3'd2, 10'd0,    1'b0, 1'b0);

        drain();
        write_reg(CFG_TRUST_MAX, 8'd255);
        write_reg(CFG_SPARE_IDX3, 8'hff);
        send_word(3'd3, 10'd1023, 1'b0, 1'b0);
        send_word(3'd3, 10'd1023, 1'b0, 1'b0);
        send_word(3'd3, 10'h155,  1'b1, 1'b1);

        // random phases, each under a fresh setting
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            pick = int'($urandom_range(0, 5));
            mode = (pick > 3) ? MODE_TREND : MODE_BITS'(pick);
            data = CFG_DATA_BITS'($urandom);
            data[MODE_BITS-1:0] = mode;
            write_reg(CFG_FILTER_MODE, data);
            pick = int'($urandom_range(0, 5));
            if (pick == 0) data = 8'd1;
            else if (pick == 1) data = 8'd255;
            else if (pick == 2) data = 8'd0;
            else data = CFG_DATA_BITS'($urandom_range(1, 255));
            write_reg(CFG_TRUST_MAX, data);
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_IDX2 : CFG_SPARE_IDX3,
                          CFG_DATA_BITS'($urandom));
            end
            quiet    = (phase == 3);
            pause_at = int'($urandom_range(20, ITEMS_PER_PHASE - 20));
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // sender holds off mid-phase until the pipe is empty
                if (i == pause_at) drain();
                send_random();
            end
        end
        quiet = 1'b0;

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
